/* rtl/core/u8e_pkg.sv */
// ----------------------------------------------------------------------------
// u8e_pkg
// shared types, constants and helpers of the utf-8 sanitizing escaper
// ----------------------------------------------------------------------------
package u8e_pkg;

    localparam logic [7:0]  CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0]  CHAR_X         = 8'h78;
    localparam logic [7:0]  CHAR_DEL       = 8'h7f;
    localparam logic [7:0]  CHAR_SPACE     = 8'h20;
    localparam logic [7:0]  LEAD2_LOW      = 8'hc2;
    localparam logic [7:0]  LEAD2_HIGH     = 8'hdf;
    localparam logic [7:0]  LEAD3_LOW      = 8'he0;
    localparam logic [7:0]  LEAD3_HIGH     = 8'hef;
    localparam logic [7:0]  LEAD4_LOW      = 8'hf0;
    localparam logic [7:0]  LEAD4_HIGH     = 8'hf4;

    localparam logic [20:0] CP_MIN2        = 21'h000080;
    localparam logic [20:0] CP_MIN3        = 21'h000800;
    localparam logic [20:0] CP_MIN4        = 21'h010000;
    localparam logic [20:0] CP_MAX         = 21'h10ffff;
    localparam logic [20:0] SURR_LOW       = 21'h00d800;
    localparam logic [20:0] SURR_HIGH      = 21'h00dfff;
    localparam logic [20:0] C1_LOW         = 21'h000080;
    localparam logic [20:0] C1_HIGH        = 21'h00009f;
    localparam logic [20:0] BIDI_OVR_LOW   = 21'h00202a;
    localparam logic [20:0] BIDI_OVR_HIGH  = 21'h00202e;
    localparam logic [20:0] BIDI_ISO_LOW   = 21'h002066;
    localparam logic [20:0] BIDI_ISO_HIGH  = 21'h002069;

    typedef enum logic [1:0] {
        ESC_SLASH = 2'd0,
        ESC_X     = 2'd1,
        ESC_HI    = 2'd2,
        ESC_LO    = 2'd3
    } esc_pos_t;

    typedef logic [2:0][7:0] held_t;

    typedef struct packed {
        logic [1:0]  count;
        logic [2:0]  length;
        logic [20:0] cp;
    } seq_t;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [3:0]      esc;
        logic [1:0]      last_idx;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
        begin
            hex_char = 8'h30 + wide;
        end
        else
        begin
            hex_char = 8'h57 + wide;
        end
    endfunction

endpackage

/* rtl/core/u8e_decode.sv */
// ----------------------------------------------------------------------------
// u8e_decode
// classifies one byte against the held sequence, gives the next sequence
// state and the list of up to four words to send, raw or escaped
// ----------------------------------------------------------------------------
module u8e_decode (
    input  logic [7:0]    byte_in,
    input  logic          end_in,
    input  u8e_pkg::seq_t seq,
    input  u8e_pkg::held_t held,
    output u8e_pkg::seq_t seq_next,
    output u8e_pkg::held_t held_next,
    output u8e_pkg::job_t job,
    output logic          job_any
);
    import u8e_pkg::*;

    logic        is_cont;
    logic        is_ctrl;
    logic        is_ascii;
    logic [2:0]  lead_len;
    logic [20:0] lead_cp;
    logic [20:0] cp_full;
    logic [20:0] cp_min;
    logic        cp_good;
    logic        cp_special;
    logic        append;
    logic        emit_held;
    logic        held_esc;
    logic        emit_b;
    logic        b_esc;
    logic [1:0]  pos;

    assign is_cont  = (byte_in[7:6] == 2'b10);
    assign is_ctrl  = (byte_in < CHAR_SPACE) || (byte_in == CHAR_DEL);
    assign is_ascii = !byte_in[7];
    assign cp_full  = {seq.cp[14:0], byte_in[5:0]};
    assign append   = (({1'b0, seq.count} + 3'd1) < seq.length) && (seq.count < 2'd3);

    always_comb
    begin
        lead_len = 3'd0;
        lead_cp  = '0;
        if ((byte_in >= LEAD2_LOW) && (byte_in <= LEAD2_HIGH))
        begin
            lead_len = 3'd2;
            lead_cp  = {16'h0, byte_in[4:0]};
        end
        else if ((byte_in >= LEAD3_LOW) && (byte_in <= LEAD3_HIGH))
        begin
            lead_len = 3'd3;
            lead_cp  = {17'h0, byte_in[3:0]};
        end
        else if ((byte_in >= LEAD4_LOW) && (byte_in <= LEAD4_HIGH))
        begin
            lead_len = 3'd4;
            lead_cp  = {18'h0, byte_in[2:0]};
        end
    end

    always_comb
    begin
        if (seq.length == 3'd2)
        begin
            cp_min = CP_MIN2;
        end
        else if (seq.length == 3'd3)
        begin
            cp_min = CP_MIN3;
        end
        else
        begin
            cp_min = CP_MIN4;
        end
    end

    assign cp_special = ((cp_full >= C1_LOW) && (cp_full <= C1_HIGH)) ||
                        ((cp_full >= BIDI_OVR_LOW) && (cp_full <= BIDI_OVR_HIGH)) ||
                        ((cp_full >= BIDI_ISO_LOW) && (cp_full <= BIDI_ISO_HIGH));
    assign cp_good    = (cp_full >= cp_min) && (cp_full <= CP_MAX) &&
                        !((cp_full >= SURR_LOW) && (cp_full <= SURR_HIGH)) && !cp_special;

    always_comb
    begin
        emit_held = 1'b0;
        held_esc  = 1'b1;
        emit_b    = 1'b0;
        b_esc     = 1'b1;
        seq_next  = '0;
        held_next = held;
        if ((seq.count == 2'd0) || !is_cont)
        begin
            // fresh byte, after flushing any broken sequence
            emit_held = (seq.count != 2'd0);
            if (is_ctrl)
            begin
                emit_b = 1'b1;
            end
            else if (is_ascii)
            begin
                emit_b = 1'b1;
                b_esc  = 1'b0;
            end
            else if (lead_len != 3'd0)
            begin
                if (end_in)
                begin
                    emit_b = 1'b1;
                end
                else
                begin
                    seq_next     = '{count: 2'd1, length: lead_len, cp: lead_cp};
                    held_next[0] = byte_in;
                end
            end
            else
            begin
                emit_b = 1'b1;
            end
        end
        else if (append)
        begin
            if (end_in)
            begin
                emit_held = 1'b1;
                emit_b    = 1'b1;
            end
            else
            begin
                seq_next = '{count: seq.count + 2'd1, length: seq.length, cp: cp_full};
                for (int i = 0; i < 3; i++)
                begin
                    if (seq.count == 2'(i))
                    begin
                        held_next[i] = byte_in;
                    end
                end
            end
        end
        else
        begin
            emit_held = 1'b1;
            emit_b    = 1'b1;
            held_esc  = !cp_good;
            b_esc     = !cp_good;
        end
    end

    assign pos     = emit_held ? seq.count : 2'd0;
    assign job_any = emit_held || emit_b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job.data[i] = held[i];
        end
        job.data[3]   = byte_in;
        job.esc       = {4{held_esc}};
        job.data[pos] = byte_in;
        job.esc[pos]  = b_esc;
        job.last_idx  = emit_b ? pos : pos - 2'd1;
    end

endmodule

/* rtl/core/u8e_emit.sv */
// ----------------------------------------------------------------------------
// u8e_emit
// holds one decoded job and sends its words one per cycle, unless out_stall
// holds the output, through the output register, expanding escaped entries
// to backslash, x and two digits
module u8e_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_load,
    input  u8e_pkg::job_t job,
    output logic          job_ready,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          run_last
);
    import u8e_pkg::*;

    job_t       job_reg;
    job_t       job_next;
    logic       job_valid_reg;
    logic       job_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    esc_pos_t   sub_reg;
    esc_pos_t   sub_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       run_last_reg;
    logic       run_last_next;

    logic [7:0] ent_byte;
    logic       ent_esc;
    logic [7:0] cur_byte;
    logic       ent_end;
    logic       job_end;
    logic       take;
    logic       step;
    logic       done;

    assign ent_byte = job_reg.data[idx_reg];
    assign ent_esc  = job_reg.esc[idx_reg];
    assign ent_end  = !ent_esc || (sub_reg == ESC_LO);
    assign job_end  = ent_end && (idx_reg == job_reg.last_idx);

    assign take      = !out_valid_reg || !out_stall;
    assign step      = job_valid_reg && take;
    assign done      = step && job_end;
    assign job_ready = !job_valid_reg || done;

    always_comb
    begin
        if (!ent_esc)
        begin
            cur_byte = ent_byte;
        end
        else
        begin
            unique case (sub_reg)
                ESC_SLASH: cur_byte = CHAR_BACKSLASH;
                ESC_X:     cur_byte = CHAR_X;
                ESC_HI:    cur_byte = hex_char(ent_byte[7:4]);
                ESC_LO:    cur_byte = hex_char(ent_byte[3:0]);
                default:   cur_byte = CHAR_BACKSLASH;
            endcase
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        sub_next       = sub_reg;
        if (job_load)
        begin
            job_next       = job;
            job_valid_next = 1'b1;
            idx_next       = 2'd0;
            sub_next       = ESC_SLASH;
        end
        else if (done)
        begin
            job_valid_next = 1'b0;
        end
        else if (step)
        begin
            if (ent_end)
            begin
                idx_next = idx_reg + 2'd1;
                sub_next = ESC_SLASH;
            end
            else
            begin
                unique case (sub_reg)
                    ESC_SLASH: sub_next = ESC_X;
                    ESC_X:     sub_next = ESC_HI;
                    ESC_HI:    sub_next = ESC_LO;
                    ESC_LO:    sub_next = ESC_SLASH;
                    default:   sub_next = ESC_SLASH;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        if (take)
        begin
            out_valid_next = job_valid_reg;
        end
        if (step)
        begin
            out_byte_next = cur_byte;
            run_last_next = job_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            sub_reg       <= ESC_SLASH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

/* rtl/core/utf8_sanitizing_escaper.sv */
// ----------------------------------------------------------------------------
// utf8_sanitizing_escaper
// passes printable ascii and well-formed utf-8, escapes controls, c1 and
// bidi controls and malformed sequences as lowercase \xHH
//
//   channel  dir  payload                 handshake
//   input    in   in_byte, end_of_text    in_valid / in_stall
//   output   out  out_byte, run_last      out_valid / out_stall
//
// one output word per cycle unless out_stall holds it: a passed byte gives one word,
// an escaped byte four, so one input gives 0 to 16 words on the output port
// the serializer in u8e_emit sets the rate; the next byte is decoded while
// the current job drains, so jobs follow without a gap
// a held lead or continuation byte gives no output
// reset clears the sequence state and all valid flags; out_stall holds the
// output word and backs up through the job register into in_stall
// ----------------------------------------------------------------------------
module utf8_sanitizing_escaper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last
);
    import u8e_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic [7:0] in_byte_next;
    logic       in_end_reg;
    logic       in_end_next;
    seq_t       seq_reg;
    seq_t       seq_next;
    seq_t       seq_dec;
    held_t      held_reg;
    held_t      held_next;
    held_t      held_dec;
    job_t       job;
    logic       job_any;
    logic       job_ready;
    logic       move;
    logic       accept;

    assign move     = in_valid_reg && (job_ready || !job_any);
    assign in_stall = in_valid_reg && !(job_ready || !job_any);
    assign accept   = in_valid && !in_stall;

    u8e_decode u_decode (
        .byte_in   (in_byte_reg),
        .end_in    (in_end_reg),
        .seq       (seq_reg),
        .held      (held_reg),
        .seq_next  (seq_dec),
        .held_next (held_dec),
        .job       (job),
        .job_any   (job_any)
    );

    u8e_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (move && job_any),
        .job       (job),
        .job_ready (job_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_end_next   = in_end_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = in_byte;
            in_end_next   = end_of_text;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
        seq_next  = move ? seq_dec : seq_reg;
        held_next = move ? held_dec : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            seq_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            seq_reg      <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_end_reg  <= in_end_next;
        held_reg    <= held_next;
    end

endmodule

/* rtl/core/u8e_check.sv */
// ----------------------------------------------------------------------------
// u8e_check
// port-level checks of the escaper, bound to the top level
// ----------------------------------------------------------------------------
module u8e_check (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last
);
    import u8e_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("output word changed under stall");

    // controls never leave unescaped
    a_no_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte >= CHAR_SPACE) && (out_byte != CHAR_DEL))
        else $error("raw control byte on output");

    // bytes that can never be part of utf-8 never pass through
    a_no_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte != 8'hc0) && (out_byte != 8'hc1) && (out_byte < 8'hf5))
        else $error("invalid utf-8 byte on output");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_sanitizing_escaper u8e_check u_check (.*);
